@@ rtl/assert_macros.svh @@
// Assertion macros shared by the permuter RTL.
// Plain text macros only; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mrp_pkg.sv @@
// Shared types, widths, register codes and reciprocal table for the permuter.
// No dependencies; used by every module of the block.
package mrp_pkg;

  localparam int IDX_W              = 16;
  localparam int DIGIT_W            = 4;
  localparam int ORDER_W            = 3;
  localparam int RADIX_SLOTS        = 8;
  localparam int COUNT_W            = 4;
  localparam int LANES              = 2;
  localparam int DEFAULT_MAX_DIGITS = 8;
  localparam int INDEX_BITS         = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_TABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_ORDER = 2'd2;

  // Reciprocal divide: q = (x * ceil(2^RECIP_SHIFT / r)) >> RECIP_SHIFT, exact for
  // 16-bit x and r up to 16
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 21;
  localparam int PROD_W      = IDX_W + RECIP_W;

  typedef logic [RECIP_W-1:0] recip_t;

  // Indexed by radix minus one
  localparam recip_t RECIP [RADIX_SLOTS*2] = '{
    21'd1048576, 21'd524288, 21'd349526, 21'd262144,
    21'd209716,  21'd174763, 21'd149797, 21'd131072,
    21'd116509,  21'd104858, 21'd95326,  21'd87382,
    21'd80660,   21'd74899,  21'd69906,  21'd65536
  };

  // Output wrap: weighted sum is kept modulo 2^min(INDEX_BITS, IDX_W)
  localparam int KEEP_BITS = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
  localparam logic [IDX_W-1:0] OUT_MASK = IDX_W'((64'd1 << KEEP_BITS) - 64'd1);

  typedef struct packed {
    logic [COUNT_W-1:0]               n_used;
    logic [RADIX_SLOTS*DIGIT_W-1:0]   radix;
    logic [RADIX_SLOTS*ORDER_W-1:0]   order;
  } cfg_t;

endpackage

@@ rtl/mixed_radix_index_permuter.sv @@
// Top level of the mixed-radix index permuter: config registers, split and place chains.
// Depends on mrp_pkg, mrp_split_cell and mrp_place_cell.
//
//  port group | direction | flow control       | word
//  in_*       | input     | in_valid/in_stall  | dest_row, dest_col
//  out_*      | output    | out_valid/out_stall| source_row, source_col, out_of_range
//  cfg_*      | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One word per cycle sustained while out_stall stays low; the pipeline is built from
// two stages per split cell (reciprocal multiply, then remainder multiply) and
// one per place cell. Synchronous active-low reset clears the pipeline valids and
// the config registers; no clearing pass. A stall on the output holds only the
// stages that are full, so bubbles ahead of it keep filling.

module mixed_radix_index_permuter #(
  parameter int MAX_DIGITS = mrp_pkg::DEFAULT_MAX_DIGITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mrp_pkg::IDX_W-1:0]       in_dest_row,
  input  logic [mrp_pkg::IDX_W-1:0]       in_dest_col,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mrp_pkg::IDX_W-1:0]       out_source_row,
  output logic [mrp_pkg::IDX_W-1:0]       out_source_col,
  output logic                            out_out_of_range,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mrp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mrp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int LANES   = mrp_pkg::LANES;
  localparam int IDX_W   = mrp_pkg::IDX_W;
  localparam int DIGIT_W = mrp_pkg::DIGIT_W;
  localparam int COUNT_W = mrp_pkg::COUNT_W;

  logic [COUNT_W-1:0]                                   digit_count_r;
  logic [mrp_pkg::RADIX_SLOTS*DIGIT_W-1:0]              radix_table_r;
  logic [mrp_pkg::RADIX_SLOTS*mrp_pkg::ORDER_W-1:0]     digit_order_r;
  mrp_pkg::cfg_t                                        cfg;

  logic                                          split_valid  [MAX_DIGITS+1];
  logic                                          split_ready  [MAX_DIGITS+1];
  logic [LANES-1:0][IDX_W-1:0]                   split_quo    [MAX_DIGITS+1];
  logic [LANES-1:0][MAX_DIGITS-1:0][DIGIT_W-1:0] split_digits [MAX_DIGITS+1];

  logic                                          place_valid  [MAX_DIGITS+1];
  logic                                          place_ready  [MAX_DIGITS+1];
  logic [LANES-1:0][IDX_W-1:0]                   place_acc    [MAX_DIGITS+1];
  logic [IDX_W-1:0]                              place_weight [MAX_DIGITS+1];
  logic [LANES-1:0][MAX_DIGITS-1:0][DIGIT_W-1:0] place_digits [MAX_DIGITS+1];
  logic                                          place_oor    [MAX_DIGITS+1];

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r <= '0;
      radix_table_r <= '0;
      digit_order_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mrp_pkg::REG_DIGIT_COUNT: digit_count_r <= cfg_data[COUNT_W-1:0];
        mrp_pkg::REG_RADIX_TABLE: radix_table_r <= cfg_data[$bits(radix_table_r)-1:0];
        mrp_pkg::REG_DIGIT_ORDER: digit_order_r <= cfg_data[$bits(digit_order_r)-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the digit count to the chain length
  assign cfg.n_used = (digit_count_r > COUNT_W'(MAX_DIGITS)) ? COUNT_W'(MAX_DIGITS)
                                                           : digit_count_r;
  assign cfg.radix  = radix_table_r;
  assign cfg.order  = digit_order_r;

  // Feed the split chain; lane 0 is the row, lane 1 the column
  assign split_valid[0]  = in_valid;
  assign in_stall        = !split_ready[0];
  assign split_quo[0][0] = in_dest_row;
  assign split_quo[0][1] = in_dest_col;
  assign split_digits[0] = '0;

  for (genvar p = 0; p < MAX_DIGITS; p++) begin : g_split
    mrp_split_cell #(
      .MAX_DIGITS (MAX_DIGITS),
      .POS        (p)
    ) u_split (
      .clk        (clk),
      .rst_n      (rst_n),
      .cfg        (cfg),
      .in_valid   (split_valid[p]),
      .in_ready   (split_ready[p]),
      .in_quo     (split_quo[p]),
      .in_digits  (split_digits[p]),
      .out_valid  (split_valid[p+1]),
      .out_ready  (split_ready[p+1]),
      .out_quo    (split_quo[p+1]),
      .out_digits (split_digits[p+1])
    );
  end

  // Hand over to the place chain; a leftover quotient means out of range
  assign place_valid[0]          = split_valid[MAX_DIGITS];
  assign split_ready[MAX_DIGITS] = place_ready[0];
  assign place_acc[0]            = '0;
  assign place_weight[0]         = IDX_W'(1);
  assign place_digits[0]         = split_digits[MAX_DIGITS];
  assign place_oor[0]            = (|split_quo[MAX_DIGITS][0]) || (|split_quo[MAX_DIGITS][1]);

  for (genvar j = 0; j < MAX_DIGITS; j++) begin : g_place
    mrp_place_cell #(
      .MAX_DIGITS (MAX_DIGITS),
      .POS        (j)
    ) u_place (
      .clk        (clk),
      .rst_n      (rst_n),
      .cfg        (cfg),
      .in_valid   (place_valid[j]),
      .in_ready   (place_ready[j]),
      .in_acc     (place_acc[j]),
      .in_weight  (place_weight[j]),
      .in_digits  (place_digits[j]),
      .in_oor     (place_oor[j]),
      .out_valid  (place_valid[j+1]),
      .out_ready  (place_ready[j+1]),
      .out_acc    (place_acc[j+1]),
      .out_weight (place_weight[j+1]),
      .out_digits (place_digits[j+1]),
      .out_oor    (place_oor[j+1])
    );
  end

  // Drive the result word; out-of-range words carry zero indexes
  assign out_valid                = place_valid[MAX_DIGITS];
  assign place_ready[MAX_DIGITS]  = !out_stall;
  assign out_out_of_range         = place_oor[MAX_DIGITS];
  assign out_source_row = place_oor[MAX_DIGITS] ? '0
                        : (place_acc[MAX_DIGITS][0] & mrp_pkg::OUT_MASK);
  assign out_source_col = place_oor[MAX_DIGITS] ? '0
                        : (place_acc[MAX_DIGITS][1] & mrp_pkg::OUT_MASK);

endmodule

@@ rtl/mrp_split_cell.sv @@
// Digit split cell: peels one mixed-radix digit off the row and column quotients.
// Two register stages (reciprocal multiply, remainder). Uses mrp_pkg, assert_macros.svh.
`include "assert_macros.svh"

module mrp_split_cell #(
  parameter int MAX_DIGITS = mrp_pkg::DEFAULT_MAX_DIGITS,
  parameter int POS        = 0
) (
  input  logic                                                       clk,
  input  logic                                                       rst_n,
  input  mrp_pkg::cfg_t                                              cfg,
  input  logic                                                       in_valid,
  output logic                                                       in_ready,
  input  logic [mrp_pkg::LANES-1:0][mrp_pkg::IDX_W-1:0]              in_quo,
  input  logic [mrp_pkg::LANES-1:0][MAX_DIGITS-1:0][mrp_pkg::DIGIT_W-1:0] in_digits,
  output logic                                                       out_valid,
  input  logic                                                       out_ready,
  output logic [mrp_pkg::LANES-1:0][mrp_pkg::IDX_W-1:0]              out_quo,
  output logic [mrp_pkg::LANES-1:0][MAX_DIGITS-1:0][mrp_pkg::DIGIT_W-1:0] out_digits
);

  localparam int LANES   = mrp_pkg::LANES;
  localparam int IDX_W   = mrp_pkg::IDX_W;
  localparam int DIGIT_W = mrp_pkg::DIGIT_W;
  localparam int PROD_W  = mrp_pkg::PROD_W;

  logic               act;
  logic [DIGIT_W-1:0] r_m1;

  logic                                            a_valid_r;
  logic                                            a_act_r;
  logic [DIGIT_W-1:0]                              a_rm1_r;
  logic [LANES-1:0][IDX_W-1:0]                     a_quo_r;
  logic [LANES-1:0][MAX_DIGITS-1:0][DIGIT_W-1:0]   a_dig_r;
  logic [LANES-1:0][PROD_W-1:0]                    a_prod_r;
  logic                                            a_ready;

  logic                                            b_valid_r;
  logic [LANES-1:0][IDX_W-1:0]                     b_quo_r;
  logic [LANES-1:0][MAX_DIGITS-1:0][DIGIT_W-1:0]   b_dig_r;
  logic                                            b_ready;

  logic [DIGIT_W:0]                                r_full;
  logic [LANES-1:0][IDX_W-1:0]                     q;
  logic [LANES-1:0][IDX_W-1:0]                     rem;
  logic [LANES-1:0][IDX_W-1:0]                     b_quo_nxt;
  logic [LANES-1:0][MAX_DIGITS-1:0][DIGIT_W-1:0]   b_dig_nxt;

  // Per-cell view of the configuration
  assign act  = (mrp_pkg::COUNT_W'(POS) < cfg.n_used);
  assign r_m1 = cfg.radix[POS*DIGIT_W +: DIGIT_W];

  // Stage A: multiply by the radix reciprocal
  assign a_ready = !a_valid_r || b_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_act_r <= act;
      a_rm1_r <= r_m1;
      a_quo_r <= in_quo;
      a_dig_r <= in_digits;
      for (int l = 0; l < LANES; l++) begin
        a_prod_r[l] <= PROD_W'(in_quo[l]) * PROD_W'(mrp_pkg::RECIP[r_m1]);
      end
    end
  end

  // Stage B: quotient, remainder and digit insert
  assign b_ready = !b_valid_r || out_ready;
  assign r_full  = {1'b0, a_rm1_r} + (DIGIT_W+1)'(1);

  always_comb begin
    b_dig_nxt = a_dig_r;
    for (int l = 0; l < LANES; l++) begin
      q[l]   = a_prod_r[l][mrp_pkg::RECIP_SHIFT +: IDX_W];
      rem[l] = a_quo_r[l] - IDX_W'(q[l] * IDX_W'(r_full));
      b_quo_nxt[l] = a_act_r ? q[l] : a_quo_r[l];
      if (a_act_r) begin
        b_dig_nxt[l][POS] = rem[l][DIGIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid_r && b_ready) begin
      b_quo_r <= b_quo_nxt;
      b_dig_r <= b_dig_nxt;
    end
  end

  assign in_ready   = a_ready;
  assign out_valid  = b_valid_r;
  assign out_quo    = b_quo_r;
  assign out_digits = b_dig_r;

  // Reciprocal divide must leave a remainder below the radix
  `ASSERT_IMPL(a_rem_row_lt_radix, clk, rst_n, a_valid_r && a_act_r,
    rem[0] <= IDX_W'(a_rm1_r), "split cell: row remainder not below radix")
  `ASSERT_IMPL(a_rem_col_lt_radix, clk, rst_n, a_valid_r && a_act_r,
    rem[1] <= IDX_W'(a_rm1_r), "split cell: column remainder not below radix")
  // A blocked stage A word must stay put
  `ASSERT_NEXT(a_hold_on_block, clk, rst_n, a_valid_r && !b_ready,
    a_valid_r && $stable(a_quo_r) && $stable(a_prod_r), "split cell: stage A word lost")

endmodule

@@ rtl/mrp_place_cell.sv @@
// Digit place cell: adds one operator-order digit into the row and column sums.
// One register stage; carries the running weight. Uses mrp_pkg, assert_macros.svh.
`include "assert_macros.svh"

module mrp_place_cell #(
  parameter int MAX_DIGITS = mrp_pkg::DEFAULT_MAX_DIGITS,
  parameter int POS        = 0
) (
  input  logic                                                       clk,
  input  logic                                                       rst_n,
  input  mrp_pkg::cfg_t                                              cfg,
  input  logic                                                       in_valid,
  output logic                                                       in_ready,
  input  logic [mrp_pkg::LANES-1:0][mrp_pkg::IDX_W-1:0]              in_acc,
  input  logic [mrp_pkg::IDX_W-1:0]                                  in_weight,
  input  logic [mrp_pkg::LANES-1:0][MAX_DIGITS-1:0][mrp_pkg::DIGIT_W-1:0] in_digits,
  input  logic                                                       in_oor,
  output logic                                                       out_valid,
  input  logic                                                       out_ready,
  output logic [mrp_pkg::LANES-1:0][mrp_pkg::IDX_W-1:0]              out_acc,
  output logic [mrp_pkg::IDX_W-1:0]                                  out_weight,
  output logic [mrp_pkg::LANES-1:0][MAX_DIGITS-1:0][mrp_pkg::DIGIT_W-1:0] out_digits,
  output logic                                                       out_oor
);

  localparam int LANES   = mrp_pkg::LANES;
  localparam int IDX_W   = mrp_pkg::IDX_W;
  localparam int DIGIT_W = mrp_pkg::DIGIT_W;
  localparam int ORDER_W = mrp_pkg::ORDER_W;

  logic                          act;
  logic [ORDER_W-1:0]            q;
  logic                          use_q;
  logic [DIGIT_W-1:0]            rsel_m1;
  logic [DIGIT_W:0]              rsel;
  logic [LANES-1:0][DIGIT_W-1:0] d;

  logic [LANES-1:0][IDX_W-1:0]                   acc_nxt;
  logic [IDX_W-1:0]                              weight_nxt;

  logic                                          valid_r;
  logic [LANES-1:0][IDX_W-1:0]                   acc_r;
  logic [IDX_W-1:0]                              weight_r;
  logic [LANES-1:0][MAX_DIGITS-1:0][DIGIT_W-1:0] dig_r;
  logic                                          oor_r;
  logic                                          ready;

  // Canonical position carried by this operator position
  assign act   = (mrp_pkg::COUNT_W'(POS) < cfg.n_used);
  assign q     = cfg.order[POS*ORDER_W +: ORDER_W];
  assign use_q = act && (mrp_pkg::COUNT_W'(q) < cfg.n_used);

  // Pick the radix and digits of that position
  always_comb begin
    rsel_m1 = '0;
    d       = '0;
    for (int k = 0; k < mrp_pkg::RADIX_SLOTS; k++) begin
      if (ORDER_W'(k) == q) begin
        rsel_m1 = cfg.radix[k*DIGIT_W +: DIGIT_W];
      end
    end
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (ORDER_W'(k) == q && use_q) begin
        for (int l = 0; l < LANES; l++) begin
          d[l] = in_digits[l][k];
        end
      end
    end
  end

  assign rsel = {1'b0, rsel_m1} + (DIGIT_W+1)'(1);

  // Accumulate digit times weight, advance the weight
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      acc_nxt[l] = in_acc[l] + IDX_W'(in_weight * IDX_W'(d[l]));
    end
    weight_nxt = use_q ? IDX_W'(in_weight * IDX_W'(rsel)) : in_weight;
  end

  assign ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ready) begin
      acc_r    <= acc_nxt;
      weight_r <= weight_nxt;
      dig_r    <= in_digits;
      oor_r    <= in_oor;
    end
  end

  assign in_ready   = ready;
  assign out_valid  = valid_r;
  assign out_acc    = acc_r;
  assign out_weight = weight_r;
  assign out_digits = dig_r;
  assign out_oor    = oor_r;

  // A blocked word must stay put
  `ASSERT_NEXT(p_hold_on_block, clk, rst_n, valid_r && !out_ready,
    valid_r && $stable(acc_r) && $stable(oor_r), "place cell: word lost under stall")

endmodule
